// ===== sv/cs3_pkg.sv =====
// Shared types for the 3x3 Cramer solver.
// No dependencies; compiled first.
`default_nettype none

package cs3_pkg;

   typedef struct packed {
      logic valid;
      logic advance;
   } pipe_ctl_type;

   localparam int DIM = 3;

endpackage

`default_nettype wire

// ===== sv/cs3_req_if.sv =====
// Request channel of the 3x3 Cramer solver: three columns and the right-hand side.
// Depends on nothing.
`default_nettype none

interface cs3_req_if #(
   parameter int WORD_BITS = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] col_a_x;
   logic signed [WORD_BITS-1:0] col_a_y;
   logic signed [WORD_BITS-1:0] col_a_z;
   logic signed [WORD_BITS-1:0] col_b_x;
   logic signed [WORD_BITS-1:0] col_b_y;
   logic signed [WORD_BITS-1:0] col_b_z;
   logic signed [WORD_BITS-1:0] col_c_x;
   logic signed [WORD_BITS-1:0] col_c_y;
   logic signed [WORD_BITS-1:0] col_c_z;
   logic signed [WORD_BITS-1:0] rhs_x;
   logic signed [WORD_BITS-1:0] rhs_y;
   logic signed [WORD_BITS-1:0] rhs_z;

   modport source (
      output valid, col_a_x, col_a_y, col_a_z, col_b_x, col_b_y, col_b_z,
             col_c_x, col_c_y, col_c_z, rhs_x, rhs_y, rhs_z,
      input  ready
   );
   modport sink (
      input  valid, col_a_x, col_a_y, col_a_z, col_b_x, col_b_y, col_b_z,
             col_c_x, col_c_y, col_c_z, rhs_x, rhs_y, rhs_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/cs3_rsp_if.sv =====
// Response channel of the 3x3 Cramer solver: solution and status flags.
// Depends on nothing.
`default_nettype none

interface cs3_rsp_if #(
   parameter int WORD_BITS = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] sol_x;
   logic signed [WORD_BITS-1:0] sol_y;
   logic signed [WORD_BITS-1:0] sol_z;
   logic                        singular;
   logic                        saturated;

   modport source (
      output valid, sol_x, sol_y, sol_z, singular, saturated,
      input  ready
   );
   modport sink (
      input  valid, sol_x, sol_y, sol_z, singular, saturated,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/cramer_solve_3x3_core.sv =====
// Pipelined 3x3 linear solver by Cramer's rule on signed fixed-point words.
// Takes one system per clock while no response stall holds the pipeline, and
// returns one solution per system, in order. Four stages form
// the four determinants exactly, one stage takes magnitudes and checks range,
// WORD_BITS stages of three restoring dividers make one quotient bit each,
// and the last stage clamps, applies sign and holds the result word.
// Quotients truncate toward zero and clip to the word range (saturated set);
// a zero main determinant gives zero outputs with singular set. A stall on
// the response side freezes the whole pipeline; nothing is dropped or repeated.
// Depends on cs3_pkg, cs3_req_if, cs3_rsp_if, cs3_det and cs3_div.
`default_nettype none

module cramer_solve_3x3_core #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input wire         clock,
   input wire         reset,
   cs3_req_if.sink    req_ch,
   cs3_rsp_if.source  rsp_ch
);
   localparam int DIM      = cs3_pkg::DIM;
   localparam int DET_BITS = 3 * WORD_BITS + 3;
   localparam int REM_BITS = DET_BITS + WORD_BITS + FRAC_BITS;

   cs3_pkg::pipe_ctl_type       det_ctl;
   cs3_pkg::pipe_ctl_type       div_ctl;
   logic                        advance;
   logic signed [WORD_BITS-1:0] col_a [DIM];
   logic signed [WORD_BITS-1:0] col_b [DIM];
   logic signed [WORD_BITS-1:0] col_c [DIM];
   logic signed [WORD_BITS-1:0] rhs   [DIM];
   logic                        det_valid;
   logic signed [DET_BITS-1:0]  det_val [4];

   logic [DET_BITS-1:0]  den_mag;
   logic [DET_BITS-1:0]  num_mag [DIM];
   logic [REM_BITS-1:0]  num_in  [DIM];
   logic                 neg_in  [DIM];
   logic                 ps_in   [DIM];
   logic                 sing_in;

   logic [REM_BITS-1:0]  num_ff  [DIM];
   logic [DET_BITS-1:0]  den_ff;
   logic                 neg_ff  [DIM];
   logic                 ps_ff   [DIM];
   logic                 sing_ff;
   logic                 prep_valid_ff;

   logic                        out_valid;
   logic signed [WORD_BITS-1:0] sol [DIM];
   logic                        out_sing;
   logic                        out_sat;

   assign advance      = ~out_valid | rsp_ch.ready;
   assign req_ch.ready = advance;

   assign col_a = '{req_ch.col_a_x, req_ch.col_a_y, req_ch.col_a_z};
   assign col_b = '{req_ch.col_b_x, req_ch.col_b_y, req_ch.col_b_z};
   assign col_c = '{req_ch.col_c_x, req_ch.col_c_y, req_ch.col_c_z};
   assign rhs   = '{req_ch.rhs_x, req_ch.rhs_y, req_ch.rhs_z};

   always_comb begin
      det_ctl.valid   = req_ch.valid;
      det_ctl.advance = advance;
      div_ctl.valid   = prep_valid_ff;
      div_ctl.advance = advance;
   end

   cs3_det #(
      .WORD_BITS (WORD_BITS),
      .DET_BITS  (DET_BITS)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .ctl       (det_ctl),
      .col_a     (col_a),
      .col_b     (col_b),
      .col_c     (col_c),
      .rhs       (rhs),
      .valid_out (det_valid),
      .det_out   (det_val)
   );

   // take magnitudes, align numerators, flag quotients that overflow the word
   always_comb begin
      den_mag = det_val[0][DET_BITS-1] ? DET_BITS'(-det_val[0]) : DET_BITS'(det_val[0]);
      sing_in = (det_val[0] == '0);
      for (int k = 0; k < DIM; k++) begin
         num_mag[k] = det_val[k+1][DET_BITS-1] ? DET_BITS'(-det_val[k+1])
                                               : DET_BITS'(det_val[k+1]);
         num_in[k]  = REM_BITS'(num_mag[k]) << FRAC_BITS;
         neg_in[k]  = det_val[k+1][DET_BITS-1] ^ det_val[0][DET_BITS-1];
         ps_in[k]   = num_in[k] >= (REM_BITS'(den_mag) << WORD_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= det_valid;
      end
      if (advance) begin
         num_ff  <= num_in;
         den_ff  <= den_mag;
         neg_ff  <= neg_in;
         ps_ff   <= ps_in;
         sing_ff <= sing_in;
      end
   end

   cs3_div #(
      .WORD_BITS (WORD_BITS),
      .DEN_BITS  (DET_BITS),
      .REM_BITS  (REM_BITS)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .ctl           (div_ctl),
      .num           (num_ff),
      .den           (den_ff),
      .neg           (neg_ff),
      .presat        (ps_ff),
      .singular      (sing_ff),
      .valid_out     (out_valid),
      .sol           (sol),
      .singular_out  (out_sing),
      .saturated_out (out_sat)
   );

   assign rsp_ch.valid     = out_valid;
   assign rsp_ch.sol_x     = sol[0];
   assign rsp_ch.sol_y     = sol[1];
   assign rsp_ch.sol_z     = sol[2];
   assign rsp_ch.singular  = out_sing;
   assign rsp_ch.saturated = out_sat;

endmodule

`default_nettype wire

// ===== sv/cs3_det.sv =====
// Four-stage determinant pipeline: det(a,b,c) and the three numerators.
// Depends on cs3_pkg.
`default_nettype none

module cs3_det #(
   parameter int WORD_BITS = 32,
   parameter int DET_BITS  = 99
) (
   input  wire                         clock,
   input  wire                         reset,
   input  cs3_pkg::pipe_ctl_type       ctl,
   input  wire  signed [WORD_BITS-1:0] col_a [cs3_pkg::DIM],
   input  wire  signed [WORD_BITS-1:0] col_b [cs3_pkg::DIM],
   input  wire  signed [WORD_BITS-1:0] col_c [cs3_pkg::DIM],
   input  wire  signed [WORD_BITS-1:0] rhs   [cs3_pkg::DIM],
   output logic                        valid_out,
   output logic signed [DET_BITS-1:0]  det_out [4]
);
   localparam int P_BITS = 2 * WORD_BITS;
   localparam int X_BITS = 2 * WORD_BITS + 1;
   localparam int H_BITS = X_BITS - WORD_BITS;
   localparam int L_BITS = 2 * WORD_BITS + 1;

   function automatic int rot1(input int j);
      return (j == 2) ? 0 : j + 1;
   endfunction

   function automatic int rot2(input int j);
      return (j == 0) ? 2 : j - 1;
   endfunction

   logic signed [WORD_BITS-1:0] pu [3][3];
   logic signed [WORD_BITS-1:0] pw [3][3];
   logic signed [P_BITS-1:0]    prod_in [3][3][2];
   logic signed [P_BITS-1:0]    prod_ff [3][3][2];
   logic signed [X_BITS-1:0]    cross_in [3][3];
   logic signed [X_BITS-1:0]    cross_ff [3][3];
   logic signed [WORD_BITS-1:0] a1_ff [3];
   logic signed [WORD_BITS-1:0] a2_ff [3];
   logic signed [WORD_BITS-1:0] v1_ff [3];
   logic signed [WORD_BITS-1:0] v2_ff [3];
   logic signed [WORD_BITS-1:0] dot_e [4][3];
   logic signed [L_BITS-1:0]    lo_in [4][3];
   logic signed [L_BITS-1:0]    hi_in [4][3];
   logic signed [L_BITS-1:0]    lo_ff [4][3];
   logic signed [L_BITS-1:0]    hi_ff [4][3];
   logic signed [DET_BITS-1:0]  det_in [4];
   logic signed [DET_BITS-1:0]  det_ff [4];
   logic [3:0]                  valid_ff;

   always_comb begin
      pu[0] = col_b; pw[0] = col_c;
      pu[1] = col_c; pw[1] = col_a;
      pu[2] = col_a; pw[2] = col_b;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[k][j][0] = pu[k][rot1(j)] * pw[k][rot2(j)];
            prod_in[k][j][1] = pu[k][rot2(j)] * pw[k][rot1(j)];
            cross_in[k][j]   = X_BITS'(prod_ff[k][j][0]) - X_BITS'(prod_ff[k][j][1]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         dot_e[0][j] = a2_ff[j];
         dot_e[1][j] = v2_ff[j];
         dot_e[2][j] = v2_ff[j];
         dot_e[3][j] = v2_ff[j];
      end
      for (int d = 0; d < 4; d++) begin
         for (int j = 0; j < 3; j++) begin
            lo_in[d][j] = $signed({1'b0, cross_ff[(d == 0) ? 0 : d - 1][j][WORD_BITS-1:0]})
                          * dot_e[d][j];
            hi_in[d][j] = $signed(H_BITS'(cross_ff[(d == 0) ? 0 : d - 1][j]
                                          >>> WORD_BITS)) * dot_e[d][j];
         end
      end
      for (int d = 0; d < 4; d++) begin
         det_in[d] = '0;
         for (int j = 0; j < 3; j++) begin
            det_in[d] = det_in[d] + (DET_BITS'(hi_ff[d][j]) <<< WORD_BITS)
                        + DET_BITS'(lo_ff[d][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.advance) begin
         valid_ff <= {valid_ff[2:0], ctl.valid};
      end
      if (ctl.advance) begin
         prod_ff  <= prod_in;
         cross_ff <= cross_in;
         a1_ff    <= col_a;
         v1_ff    <= rhs;
         a2_ff    <= a1_ff;
         v2_ff    <= v1_ff;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         det_ff   <= det_in;
      end
   end

   assign valid_out = valid_ff[3];
   assign det_out   = det_ff;

endmodule

`default_nettype wire

// ===== sv/cs3_div.sv =====
// Three-lane restoring divider, one quotient bit per stage, with clamp and sign.
// Depends on cs3_pkg.
`default_nettype none

module cs3_div #(
   parameter int WORD_BITS = 32,
   parameter int DEN_BITS  = 99,
   parameter int REM_BITS  = 147
) (
   input  wire                         clock,
   input  wire                         reset,
   input  cs3_pkg::pipe_ctl_type       ctl,
   input  wire  [REM_BITS-1:0]         num [cs3_pkg::DIM],
   input  wire  [DEN_BITS-1:0]         den,
   input  wire                         neg [cs3_pkg::DIM],
   input  wire                         presat [cs3_pkg::DIM],
   input  wire                         singular,
   output logic                        valid_out,
   output logic signed [WORD_BITS-1:0] sol [cs3_pkg::DIM],
   output logic                        singular_out,
   output logic                        saturated_out
);
   localparam int DIM = cs3_pkg::DIM;

   logic [REM_BITS-1:0]  rem_in [WORD_BITS][DIM];
   logic [REM_BITS-1:0]  rem_ff [WORD_BITS][DIM];
   logic [WORD_BITS-1:0] q_in   [WORD_BITS][DIM];
   logic [WORD_BITS-1:0] q_ff   [WORD_BITS][DIM];
   logic [REM_BITS-1:0]  trial  [WORD_BITS];
   logic [REM_BITS-1:0]  src_rem [WORD_BITS][DIM];
   logic [WORD_BITS-1:0] src_q   [WORD_BITS][DIM];
   logic [DEN_BITS-1:0]  den_ff [WORD_BITS];
   logic                 neg_ff [WORD_BITS][DIM];
   logic                 ps_ff  [WORD_BITS][DIM];
   logic                 sing_ff [WORD_BITS];
   logic [WORD_BITS-1:0] valid_ff;

   logic [WORD_BITS-1:0]        lim   [DIM];
   logic                        clip  [DIM];
   logic [WORD_BITS-1:0]        qsat  [DIM];
   logic signed [WORD_BITS-1:0] sol_in [DIM];
   logic                        sat_in;
   logic signed [WORD_BITS-1:0] sol_ff [DIM];
   logic                        sing_out_ff;
   logic                        sat_ff;
   logic                        out_valid_ff;

   always_comb begin
      for (int s = 0; s < WORD_BITS; s++) begin
         trial[s] = REM_BITS'(s == 0 ? den : den_ff[s-1]) << (WORD_BITS - 1 - s);
         for (int k = 0; k < DIM; k++) begin
            src_rem[s][k] = (s == 0) ? num[k] : rem_ff[s-1][k];
            src_q[s][k]   = (s == 0) ? '0 : q_ff[s-1][k];
            if (src_rem[s][k] >= trial[s]) begin
               rem_in[s][k] = src_rem[s][k] - trial[s];
               q_in[s][k]   = src_q[s][k] | (WORD_BITS'(1) << (WORD_BITS - 1 - s));
            end else begin
               rem_in[s][k] = src_rem[s][k];
               q_in[s][k]   = src_q[s][k];
            end
         end
      end
      sat_in = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         lim[k]  = neg_ff[WORD_BITS-1][k] ? (WORD_BITS'(1) << (WORD_BITS - 1))
                                          : ((WORD_BITS'(1) << (WORD_BITS - 1)) - 1'b1);
         clip[k] = ps_ff[WORD_BITS-1][k] || (q_ff[WORD_BITS-1][k] > lim[k]);
         qsat[k] = clip[k] ? lim[k] : q_ff[WORD_BITS-1][k];
         if (sing_ff[WORD_BITS-1]) begin
            sol_in[k] = '0;
         end else begin
            sol_in[k] = neg_ff[WORD_BITS-1][k] ? $signed(-qsat[k]) : $signed(qsat[k]);
         end
         sat_in = sat_in | clip[k];
      end
      sat_in = sat_in & ~sing_ff[WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff     <= {valid_ff[WORD_BITS-2:0], ctl.valid};
         out_valid_ff <= valid_ff[WORD_BITS-1];
      end
      if (ctl.advance) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         for (int s = 0; s < WORD_BITS; s++) begin
            den_ff[s]  <= (s == 0) ? den : den_ff[s-1];
            sing_ff[s] <= (s == 0) ? singular : sing_ff[s-1];
            for (int k = 0; k < DIM; k++) begin
               neg_ff[s][k] <= (s == 0) ? neg[k] : neg_ff[s-1][k];
               ps_ff[s][k]  <= (s == 0) ? presat[k] : ps_ff[s-1][k];
            end
         end
         sol_ff      <= sol_in;
         sat_ff      <= sat_in;
         sing_out_ff <= sing_ff[WORD_BITS-1];
      end
   end

   assign valid_out     = out_valid_ff;
   assign sol           = sol_ff;
   assign singular_out  = sing_out_ff;
   assign saturated_out = sat_ff;

endmodule

`default_nettype wire
